[rtl/core/pci_bar_size_probe_unit_macros.svh]
// assertion macros for the pci bar sizing probe unit
// no dependencies; expects clk and arst_n in the including module
`ifndef PCI_BAR_SIZE_PROBE_UNIT_MACROS_SVH
`define PCI_BAR_SIZE_PROBE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PBSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PBSP_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> expr) else $error(msg);
`else
`define PBSP_ASSERT(label, prop, msg)
`define PBSP_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

[rtl/core/pbsp_pkg.sv]
// types and constants of the pci bar sizing probe unit
// no dependencies
package pbsp_pkg;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_RESULT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ORIG_LO = 3'd1,
		PH_MASK_LO = 3'd2,
		PH_ORIG_HI = 3'd3,
		PH_MASK_HI = 3'd4
	} phase_t;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	localparam logic [5:0]  BAR_DWORD_BASE = 6'h04;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
	localparam logic [31:0] IO_BASE_MASK   = 32'hFFFF_FFFC;
	localparam logic [31:0] MEM_BASE_MASK  = 32'hFFFF_FFF0;
	localparam logic [1:0]  MEM_TYPE_64    = 2'b10;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		kind_t       kind;
		logic [31:0] cfg_address;
		logic [31:0] write_data;
		logic [63:0] bar_base;
		logic [63:0] bar_size;
		logic [3:0]  bar_flags;
		logic        is_io;
		logic        is_wide;
		logic        prefetch;
		logic        last;
	} result_t;

endpackage

[rtl/core/pci_bar_size_probe_unit.sv]
// pci bar sizing probe unit: sequences read / write-ones / read-mask / restore per bar dword
// flow: an accepted word waits in the input register stage, then its results enter the result queue
// throughput: one input word per cycle while the queue has room for two more entries; output
// drains one result per cycle while out_ready is high, through the single output port of the queue
// reset: arst_n async active low, returns to idle with an empty result queue
`include "pci_bar_size_probe_unit_macros.svh"
module pci_bar_size_probe_unit import pbsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  bus_number,
	input  logic [4:0]  device_number,
	input  logic [2:0]  function_number,
	input  logic [2:0]  bar_select,
	input  logic [31:0] read_data,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] cfg_address,
	output logic [31:0] write_data,
	output logic [63:0] bar_base,
	output logic [63:0] bar_size,
	output logic [3:0]  bar_flags,
	output logic        is_io,
	output logic        is_wide,
	output logic        prefetch,
	output logic        last
);

	// input register stage
	logic        valid_s1;
	logic        req_s1;
	logic [7:0]  bus_s1;
	logic [4:0]  dev_s1;
	logic [2:0]  fn_s1;
	logic [2:0]  bar_s1;
	logic [31:0] data_s1;

	// probe state
	phase_t      phase_q, phase_d;
	logic [31:0] target_q, target_d;
	logic [31:0] orig_low_q, orig_low_d;
	logic [31:0] mask_low_q, mask_low_d;
	logic [31:0] orig_high_q, orig_high_d;

	// result queue, written up to two entries a cycle, read at the head
	result_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q, count_d, count_after_pop;

	logic        pop;
	logic        advance;
	logic [1:0]  push_n;
	result_t     r0, r1;
	result_t     head;
	logic [31:0] start_addr, hi_addr;
	logic        orig_is_wide;

	function automatic result_t cmd_word(kind_t k, logic [31:0] addr, logic [31:0] data,
		logic is_last);
		result_t r;
		r = '0;
		r.kind = k;
		r.cfg_address = addr;
		r.write_data = data;
		r.last = is_last;
		return r;
	endfunction

	function automatic result_t result_word(logic [31:0] tgt, logic [31:0] orig_lo,
		logic [31:0] mask_lo, logic [31:0] orig_hi, logic wide, logic [31:0] mask_hi);
		result_t     r;
		logic [31:0] m32;
		logic [63:0] m64;
		r = '0;
		r.kind = KIND_RESULT;
		r.cfg_address = tgt;
		r.last = 1'b1;
		if (orig_lo[0]) begin
			// i/o space: two flag bits
			m32 = mask_lo & IO_BASE_MASK;
			r.bar_base = {32'd0, orig_lo & IO_BASE_MASK};
			r.bar_size = {32'd0, ~m32 + 32'd1};
			r.bar_flags = {2'b00, orig_lo[1:0]};
			r.is_io = 1'b1;
		end else begin
			r.bar_flags = orig_lo[3:0];
			r.prefetch = orig_lo[3];
			if (wide) begin
				m64 = {mask_hi, mask_lo & MEM_BASE_MASK};
				r.bar_base = {orig_hi, orig_lo & MEM_BASE_MASK};
				r.bar_size = ~m64 + 64'd1;
				r.is_wide = 1'b1;
			end else begin
				m32 = mask_lo & MEM_BASE_MASK;
				r.bar_base = {32'd0, orig_lo & MEM_BASE_MASK};
				r.bar_size = {32'd0, ~m32 + 32'd1};
			end
		end
		return r;
	endfunction

	// flow control: the stage advances only if the queue can take two more entries
	assign pop             = out_valid && out_ready;
	assign count_after_pop = count_q - {{(CNT_W-1){1'b0}}, pop};
	assign advance         = valid_s1 && (count_after_pop <= CNT_W'(FIFO_DEPTH - 2));
	assign in_ready        = !valid_s1 || advance;

	// address words: low dword from the start word, high dword is next offset, wrapped
	assign start_addr   = {1'b1, 7'd0, bus_s1, dev_s1, fn_s1,
		BAR_DWORD_BASE + {3'd0, bar_s1}, 2'b00};
	assign hi_addr      = {target_q[31:8], target_q[7:2] + 6'd1, 2'b00};
	assign orig_is_wide = !orig_low_q[0] && (orig_low_q[2:1] == MEM_TYPE_64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			bus_s1  <= bus_number;
			dev_s1  <= device_number;
			fn_s1   <= function_number;
			bar_s1  <= bar_select;
			data_s1 <= read_data;
		end
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		target_d    = target_q;
		orig_low_d  = orig_low_q;
		mask_low_d  = mask_low_q;
		orig_high_d = orig_high_q;
		if (advance) begin
			if (req_s1 == REQ_START) begin
				// start while busy is dropped
				if (phase_q == PH_IDLE) begin
					target_d = start_addr;
					phase_d  = PH_ORIG_LO;
				end
			end else begin
				case (phase_q)
					PH_ORIG_LO: begin
						orig_low_d = data_s1;
						phase_d    = PH_MASK_LO;
					end
					PH_MASK_LO: begin
						mask_low_d = data_s1;
						phase_d    = orig_is_wide ? PH_ORIG_HI : PH_IDLE;
					end
					PH_ORIG_HI: begin
						orig_high_d = data_s1;
						phase_d     = PH_MASK_HI;
					end
					PH_MASK_HI: begin
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// results caused by the staged word
	always_comb begin
		r0     = '0;
		r1     = '0;
		push_n = 2'd0;
		if (advance) begin
			if (req_s1 == REQ_START) begin
				if (phase_q == PH_IDLE) begin
					r0     = cmd_word(KIND_READ, start_addr, 32'd0, 1'b1);
					push_n = 2'd1;
				end
			end else begin
				case (phase_q)
					PH_ORIG_LO: begin
						r0     = cmd_word(KIND_WRITE, target_q, ALL_ONES, 1'b0);
						r1     = cmd_word(KIND_READ, target_q, 32'd0, 1'b1);
						push_n = 2'd2;
					end
					PH_MASK_LO: begin
						r0 = cmd_word(KIND_WRITE, target_q, orig_low_q, 1'b0);
						if (orig_is_wide) begin
							r1 = cmd_word(KIND_READ, hi_addr, 32'd0, 1'b1);
						end else begin
							r1 = result_word(target_q, orig_low_q, data_s1, orig_high_q,
								1'b0, 32'd0);
						end
						push_n = 2'd2;
					end
					PH_ORIG_HI: begin
						r0     = cmd_word(KIND_WRITE, hi_addr, ALL_ONES, 1'b0);
						r1     = cmd_word(KIND_READ, hi_addr, 32'd0, 1'b1);
						push_n = 2'd2;
					end
					PH_MASK_HI: begin
						r0     = cmd_word(KIND_WRITE, hi_addr, orig_high_q, 1'b0);
						r1     = result_word(target_q, orig_low_q, mask_low_q, orig_high_q,
							1'b1, data_s1);
						push_n = 2'd2;
					end
					default: begin
						push_n = 2'd0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			target_q    <= '0;
			orig_low_q  <= '0;
			mask_low_q  <= '0;
			orig_high_q <= '0;
		end else begin
			phase_q     <= phase_d;
			target_q    <= target_d;
			orig_low_q  <= orig_low_d;
			mask_low_q  <= mask_low_d;
			orig_high_q <= orig_high_d;
		end
	end

	// queue pointers and fill count
	assign count_d = count_after_pop + {{(CNT_W-2){1'b0}}, push_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= r1;
		end
	end

	// head of queue drives the output word
	assign head        = fifo_q[rd_ptr_q];
	assign out_valid   = (count_q != '0);
	assign kind        = head.kind;
	assign cfg_address = head.cfg_address;
	assign write_data  = head.write_data;
	assign bar_base    = head.bar_base;
	assign bar_size    = head.bar_size;
	assign bar_flags   = head.bar_flags;
	assign is_io       = head.is_io;
	assign is_wide     = head.is_wide;
	assign prefetch    = head.prefetch;
	assign last        = head.last;

	`PBSP_ASSERT(a_no_overflow, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`PBSP_ASSERT(a_result_last, (out_valid && kind == KIND_RESULT) |-> last, "result not last")
	`PBSP_ASSERT_NEXT(a_start_seq, advance && req_s1 == REQ_START && phase_q == PH_IDLE,
		phase_q == PH_ORIG_LO, "start did not enter original read phase")
	`PBSP_ASSERT_NEXT(a_high_done, advance && req_s1 == REQ_DATA && phase_q == PH_MASK_HI,
		phase_q == PH_IDLE, "high mask did not finish probe")

endmodule

[sim/pci_bar_size_probe_checker.sv]
// checker for the pci bar sizing probe unit: tracks the probe sequence and compares every result word
// depends on pbsp_pkg for the result layout and the kind, phase and request codes
module pci_bar_size_probe_checker import pbsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  bus_number,
	input  logic [4:0]  device_number,
	input  logic [2:0]  function_number,
	input  logic [2:0]  bar_select,
	input  logic [31:0] read_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] cfg_address,
	input  logic [31:0] write_data,
	input  logic [63:0] bar_base,
	input  logic [63:0] bar_size,
	input  logic [3:0]  bar_flags,
	input  logic        is_io,
	input  logic        is_wide,
	input  logic        prefetch,
	input  logic        last,
	output int          error_count,
	output int          pending_count,
	output int          words_seen,
	output int          words_ignored,
	output int          io_probes,
	output int          mem32_probes,
	output int          mem64_probes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 40;

	// shadow of the sequencer
	phase_t      probe_phase;
	logic [31:0] bar_addr;
	logic [31:0] orig_lo;
	logic [31:0] mask_lo;
	logic [31:0] orig_hi;

	result_t access_queue[$];
	int      mismatches;
	int      n_seen;
	int      n_ignored;
	int      n_io;
	int      n_mem32;
	int      n_mem64;
	int      n_checked;

	function automatic result_t cfg_access(kind_t k, logic [31:0] addr, logic [31:0] data,
		logic fin);
		result_t w;
		w = '0;
		w.kind = k;
		w.cfg_address = addr;
		w.write_data = data;
		w.last = fin;
		return w;
	endfunction

	// next dword after the bar, offset wraps inside the 8-bit register field
	function automatic logic [31:0] upper_dword_addr();
		logic [7:0] off;
		off = (bar_addr[7:0] & 8'hFC) + 8'd4;
		return {bar_addr[31:8], off & 8'hFC};
	endfunction

	function automatic result_t sizing_summary(logic wide, logic [31:0] mask_hi);
		result_t     w;
		logic [31:0] m32;
		logic [63:0] m64;
		w = '0;
		w.kind = KIND_RESULT;
		w.cfg_address = bar_addr;
		w.last = 1'b1;
		if (orig_lo[0]) begin
			m32 = mask_lo & IO_BASE_MASK;
			w.bar_base = {32'd0, orig_lo & IO_BASE_MASK};
			w.bar_size = {32'd0, ~m32 + 32'd1};
			w.bar_flags = {2'b00, orig_lo[1:0]};
			w.is_io = 1'b1;
		end else begin
			w.bar_flags = orig_lo[3:0];
			w.prefetch = orig_lo[3];
			if (wide) begin
				m64 = {mask_hi, mask_lo & MEM_BASE_MASK};
				w.bar_base = {orig_hi, orig_lo & MEM_BASE_MASK};
				w.bar_size = ~m64 + 64'd1;
				w.is_wide = 1'b1;
			end else begin
				m32 = mask_lo & MEM_BASE_MASK;
				w.bar_base = {32'd0, orig_lo & MEM_BASE_MASK};
				w.bar_size = {32'd0, ~m32 + 32'd1};
			end
		end
		return w;
	endfunction

	task automatic predict_accesses(logic rq, logic [7:0] bus, logic [4:0] dev, logic [2:0] fn,
		logic [2:0] bar, logic [31:0] data);
		logic [7:0] off;
		if (rq == REQ_START) begin
			if (probe_phase != PH_IDLE) begin
				n_ignored++;
				return;
			end
			off = 8'h10 + {3'b000, bar, 2'b00};
			bar_addr = {1'b1, 7'd0, bus, dev, fn, off};
			access_queue.push_back(cfg_access(KIND_READ, bar_addr, 32'd0, 1'b1));
			probe_phase = PH_ORIG_LO;
		end else begin
			case (probe_phase)
			PH_ORIG_LO: begin
				orig_lo = data;
				access_queue.push_back(cfg_access(KIND_WRITE, bar_addr, ALL_ONES, 1'b0));
				access_queue.push_back(cfg_access(KIND_READ, bar_addr, 32'd0, 1'b1));
				probe_phase = PH_MASK_LO;
			end
			PH_MASK_LO: begin
				mask_lo = data;
				access_queue.push_back(cfg_access(KIND_WRITE, bar_addr, orig_lo, 1'b0));
				if (!orig_lo[0] && orig_lo[2:1] == MEM_TYPE_64) begin
					access_queue.push_back(cfg_access(KIND_READ, upper_dword_addr(), 32'd0, 1'b1));
					probe_phase = PH_ORIG_HI;
				end else begin
					access_queue.push_back(sizing_summary(1'b0, 32'd0));
					if (orig_lo[0]) n_io++;
					else n_mem32++;
					probe_phase = PH_IDLE;
				end
			end
			PH_ORIG_HI: begin
				orig_hi = data;
				access_queue.push_back(cfg_access(KIND_WRITE, upper_dword_addr(), ALL_ONES, 1'b0));
				access_queue.push_back(cfg_access(KIND_READ, upper_dword_addr(), 32'd0, 1'b1));
				probe_phase = PH_MASK_HI;
			end
			PH_MASK_HI: begin
				access_queue.push_back(cfg_access(KIND_WRITE, upper_dword_addr(), orig_hi, 1'b0));
				access_queue.push_back(sizing_summary(1'b1, data));
				n_mem64++;
				probe_phase = PH_IDLE;
			end
			default: n_ignored++;
			endcase
		end
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %h expected %h", n_checked, name, got,
				want));
	endtask

	task automatic check_word();
		result_t want;
		if (access_queue.size() == 0) begin
			report_mismatch($sformatf("unexpected word kind %0d address %h", kind, cfg_address));
			return;
		end
		want = access_queue.pop_front();
		compare_field("kind", 64'(kind), 64'(want.kind));
		compare_field("cfg_address", 64'(cfg_address), 64'(want.cfg_address));
		compare_field("write_data", 64'(write_data), 64'(want.write_data));
		compare_field("bar_base", bar_base, want.bar_base);
		compare_field("bar_size", bar_size, want.bar_size);
		compare_field("bar_flags", 64'(bar_flags), 64'(want.bar_flags));
		compare_field("is_io", 64'(is_io), 64'(want.is_io));
		compare_field("is_wide", 64'(is_wide), 64'(want.is_wide));
		compare_field("prefetch", 64'(prefetch), 64'(want.prefetch));
		compare_field("last", 64'(last), 64'(want.last));
		n_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_phase = PH_IDLE;
			bar_addr = '0;
			orig_lo = '0;
			mask_lo = '0;
			orig_hi = '0;
			access_queue.delete();
		end else begin
			if (in_valid && in_ready) begin
				n_seen++;
				predict_accesses(req_type, bus_number, device_number, function_number, bar_select,
					read_data);
			end
			if (out_valid && out_ready) check_word();
		end
		error_count <= mismatches;
		pending_count <= access_queue.size();
		words_seen <= n_seen;
		words_ignored <= n_ignored;
		io_probes <= n_io;
		mem32_probes <= n_mem32;
		mem64_probes <= n_mem64;
	end

endmodule

[sim/pci_bar_size_probe_unit_tb.sv]
// testbench top for the pci bar sizing probe unit: clock, reset, stimulus and verdict
// depends on pbsp_pkg, pci_bar_size_probe_unit and pci_bar_size_probe_checker
module pci_bar_size_probe_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pbsp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 9;
	localparam int TARGET_WORDS   = 1500;
	localparam int HOLD_CYCLES    = 60;     // long result-side hold, fills the result queue
	localparam int DRAIN_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 8;      // margin after the drain for stray words
	localparam int TIMEOUT_CYCLES = 300000;

	// memory bar type field codes other than the 64-bit one from the package
	localparam logic [1:0] MEM_TYPE_32    = 2'b00;
	localparam logic [1:0] MEM_TYPE_RSVD1 = 2'b01;
	localparam logic [1:0] MEM_TYPE_RSVD3 = 2'b11;

	typedef enum int {
		BAR_IO,
		BAR_MEM32,
		BAR_MEM64,
		BAR_RSVD1,
		BAR_RSVD3
	} bar_class_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  bus_number;
	logic [4:0]  device_number;
	logic [2:0]  function_number;
	logic [2:0]  bar_select;
	logic [31:0] read_data;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [31:0] cfg_address;
	logic [31:0] write_data;
	logic [63:0] bar_base;
	logic [63:0] bar_size;
	logic [3:0]  bar_flags;
	logic        is_io;
	logic        is_wide;
	logic        prefetch;
	logic        last;

	int error_count;
	int pending_count;
	int words_seen;
	int words_ignored;
	int io_probes;
	int mem32_probes;
	int mem64_probes;

	// words that move the sequencer, stray words not included
	int useful_words;
	// when set the sender offers words with no gaps
	bit back_to_back;

	pci_bar_size_probe_unit u_top (.*);

	pci_bar_size_probe_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// offer one input word after a random gap, return at the edge that takes it
	// valid stays high on return so a back-to-back word needs no toggle
	task automatic offer_word(logic rq, logic [7:0] bus, logic [4:0] dev, logic [2:0] fn,
		logic [2:0] bar, logic [31:0] data);
		int gap;
		gap = back_to_back ? 0 : int'($urandom_range(0, 3));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		bus_number <= bus;
		device_number <= dev;
		function_number <= fn;
		bar_select <= bar;
		read_data <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// start word while a probe is running, the block must drop it
	task automatic stray_start(int pct);
		if ($urandom_range(0, 99) < pct)
			offer_word(REQ_START, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom),
				$urandom);
	endtask

	// read return while idle, also dropped
	task automatic stray_data();
		offer_word(REQ_DATA, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom), $urandom);
	endtask

	// one well-formed sizing probe: start, original, mask, and for a 64-bit bar the upper pair
	// address fields on read returns are don't-care and get random values
	task automatic run_probe(logic [7:0] bus, logic [4:0] dev, logic [2:0] fn, logic [2:0] bar,
		logic [31:0] lo_orig, logic [31:0] lo_mask, logic [31:0] hi_orig, logic [31:0] hi_mask,
		int noise_pct);
		logic wide;
		wide = !lo_orig[0] && lo_orig[2:1] == MEM_TYPE_64;
		offer_word(REQ_START, bus, dev, fn, bar, $urandom);
		stray_start(noise_pct);
		offer_word(REQ_DATA, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom), lo_orig);
		stray_start(noise_pct);
		offer_word(REQ_DATA, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom), lo_mask);
		useful_words += 3;
		if (wide) begin
			stray_start(noise_pct);
			offer_word(REQ_DATA, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom),
				hi_orig);
			stray_start(noise_pct);
			offer_word(REQ_DATA, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom),
				hi_mask);
			useful_words += 2;
		end
	endtask

	// random bar of a random class, masks mostly shaped like real hardware readback
	task automatic random_probe();
		bar_class_t  cls;
		logic [31:0] lo_orig;
		logic [31:0] lo_mask;
		logic [31:0] hi_orig;
		logic [31:0] hi_mask;
		logic [2:0]  bar;
		int          sz;
		cls = bar_class_t'($urandom_range(0, 4));
		// indexes six and seven are outside the standard bar range, keep them rare
		if ($urandom_range(0, 15) == 0) bar = 3'($urandom_range(6, 7));
		else bar = 3'($urandom_range(0, 5));
		lo_orig = $urandom;
		hi_orig = $urandom;
		case (cls)
		BAR_IO:    lo_orig[0] = 1'b1;
		BAR_MEM32: lo_orig[2:0] = {MEM_TYPE_32, 1'b0};
		BAR_MEM64: lo_orig[2:0] = {MEM_TYPE_64, 1'b0};
		BAR_RSVD1: lo_orig[2:0] = {MEM_TYPE_RSVD1, 1'b0};
		default:   lo_orig[2:0] = {MEM_TYPE_RSVD3, 1'b0};
		endcase
		if ($urandom_range(0, 3) == 0) begin
			lo_mask = $urandom;
			hi_mask = $urandom;
		end else begin
			// ones above the size bit, type bits read back unchanged
			sz = $urandom_range(0, 63);
			lo_mask = (sz < 32) ? (ALL_ONES << sz) : 32'd0;
			hi_mask = (sz < 32) ? ALL_ONES : (ALL_ONES << (sz - 32));
			lo_mask[3:0] = lo_orig[3:0];
		end
		run_probe(8'($urandom), 5'($urandom), 3'($urandom), bar, lo_orig, lo_mask, hi_orig,
			hi_mask, 8);
	endtask

	// result side: random stalls per word, no-stall windows, and two long holds
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ((taken / 64) % 4 == 1) stall = 0;
			else stall = $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			if (taken == 150 || taken == 1700) begin
				// sender keeps going, queue fills and in_ready must drop
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int drain;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_START;
		bus_number <= '0;
		device_number <= '0;
		function_number <= '0;
		bar_select <= '0;
		read_data <= '0;
		useful_words = 0;
		back_to_back = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: read return while idle
		stray_data();
		// io bar at the top of the bus, device and function fields, starts while busy after each busy word
		run_probe(8'hFF, 5'h1F, 3'h7, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FF01, '0, '0, 100);
		// 32-bit memory bar with all-zero readback, size wraps to zero
		run_probe(8'h00, 5'h00, 3'h0, 3'd0, 32'h0000_0000, 32'h0000_0000, '0, '0, 0);
		// 64-bit prefetchable bar at index seven, upper dword lands past the bar block
		run_probe(8'h5A, 5'h15, 3'h2, 3'd7, 32'hFFFF_FFFC, ALL_ONES, ALL_ONES, ALL_ONES, 0);
		// 64-bit bar with zero masks, size wraps at 64 bits
		run_probe(8'h01, 5'h01, 3'h1, 3'd4, 32'h0000_0004, 32'h0000_0004, '0, '0, 0);
		// reserved memory types one and three handled as 32-bit, type one at index six
		run_probe(8'h80, 5'h10, 3'h4, 3'd6, 32'h1234_567A, 32'hFFF0_000A, '0, '0, 0);
		run_probe(8'h7F, 5'h0A, 3'h3, 3'd1, 32'h8000_0006, 32'hFFFF_FFF6, '0, '0, 0);

		// random probes with stray words mixed in, some stretches without gaps
		while (useful_words < TARGET_WORDS) begin
			back_to_back = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0) stray_data();
			random_probe();
		end
		in_valid <= 1'b0;

		// wait for every expected word, then keep watching for stray words
		drain = 0;
		do begin
			@(posedge clk);
			drain++;
		end while (pending_count != 0 && drain < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d input words (%0d dropped as stray), probes: %0d io, %0d 32-bit, %0d 64-bit",
			words_seen, words_ignored, io_probes, mem32_probes, mem64_probes);
		$display("result side held off %0d cycles twice to back up the input", HOLD_CYCLES);
		if (pending_count != 0) $display("%0d expected words never arrived", pending_count);
		if (error_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout after %0d cycles", TIMEOUT_CYCLES);
		$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pbsp_pkg.sv
rtl/core/pci_bar_size_probe_unit.sv
sim/pci_bar_size_probe_checker.sv
sim/pci_bar_size_probe_unit_tb.sv
